// File: design/gcs_pkg.sv
// Package for the grapheme cluster segmenter: break classes, command codes,
// per-text tracking context and the decision flags passed between modules.
// No dependencies.
package gcs_pkg;

  localparam int unsigned CLASS_W = 4;
  localparam int unsigned BYTES_W = 3;
  localparam int unsigned OUT_W   = 32;

  localparam logic CMD_CP  = 1'b0;
  localparam logic CMD_EOT = 1'b1;

  typedef enum logic [CLASS_W-1:0] {
    CLS_OTHER   = 4'd0,
    CLS_CR      = 4'd1,
    CLS_LF      = 4'd2,
    CLS_CONTROL = 4'd3,
    CLS_EXTEND  = 4'd4,
    CLS_ZWJ     = 4'd5,
    CLS_SPACING = 4'd6,
    CLS_PREPEND = 4'd7,
    CLS_RI      = 4'd8,
    CLS_L       = 4'd9,
    CLS_V       = 4'd10,
    CLS_T       = 4'd11,
    CLS_LV      = 4'd12,
    CLS_LVT     = 4'd13
  } gb_class_e;

  typedef struct packed {
    gb_class_e prev_class;
    logic      text_open;
    logic      ri_run_odd;
    logic      after_zwj;
    logic      last_base_pict;
  } ctx_t;

  typedef struct packed {
    logic emit;
    logic open;
    logic clear;
  } dec_t;

endpackage

// File: design/gcs_in_if.sv
// Input channel of the segmenter: one code point or end-of-text mark a beat.
// Depends on gcs_pkg.
interface gcs_in_if import gcs_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [CLASS_W-1:0] gb_class;
  logic               is_pictographic;
  logic [BYTES_W-1:0] cp_bytes;

  modport source (output valid, cmd, gb_class, is_pictographic, cp_bytes, input ready);
  modport sink   (input valid, cmd, gb_class, is_pictographic, cp_bytes, output ready);
endinterface

// File: design/gcs_out_if.sv
// Output channel of the segmenter: one finished cluster (start, length) a beat.
// Depends on gcs_pkg.
interface gcs_out_if import gcs_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] cluster_start;
  logic [OUT_W-1:0] cluster_len;

  modport source (output valid, cluster_start, cluster_len, input ready);
  modport sink   (input valid, cluster_start, cluster_len, output ready);
endinterface

// File: design/gcs_rules.sv
// Boundary rule chain and context tracking for one registered beat.
// Depends on gcs_pkg.
module gcs_rules import gcs_pkg::*; (
  input  ctx_t               ctx_i,
  input  logic               cmd_i,
  input  logic [CLASS_W-1:0] gb_class_i,
  input  logic               pict_i,
  output ctx_t               ctx_o,
  output dec_t               dec_o
);

  gb_class_e cls;
  gb_class_e p;
  logic      ctl_p;
  logic      ctl_c;
  logic      bnd;
  ctx_t      base;

  assign cls = (gb_class_i > CLS_LVT) ? CLS_OTHER : gb_class_e'(gb_class_i);
  assign p   = ctx_i.prev_class;

  assign ctl_p = (p == CLS_CR) || (p == CLS_LF) || (p == CLS_CONTROL);
  assign ctl_c = (cls == CLS_CR) || (cls == CLS_LF) || (cls == CLS_CONTROL);

  always_comb begin
    if (p == CLS_CR && cls == CLS_LF) begin
      bnd = 1'b0;
    end else if (ctl_p || ctl_c) begin
      bnd = 1'b1;
    end else if (p == CLS_L && (cls == CLS_L || cls == CLS_V || cls == CLS_LV ||
                                cls == CLS_LVT)) begin
      bnd = 1'b0;
    end else if ((p == CLS_LV || p == CLS_V) && (cls == CLS_V || cls == CLS_T)) begin
      bnd = 1'b0;
    end else if ((p == CLS_LVT || p == CLS_T) && cls == CLS_T) begin
      bnd = 1'b0;
    end else if (cls == CLS_EXTEND || cls == CLS_ZWJ || cls == CLS_SPACING) begin
      bnd = 1'b0;
    end else if (p == CLS_PREPEND) begin
      bnd = 1'b0;
    end else if (pict_i && ctx_i.after_zwj) begin
      bnd = 1'b0;
    end else if (p == CLS_RI && cls == CLS_RI && ctx_i.ri_run_odd) begin
      bnd = 1'b0;
    end else begin
      bnd = 1'b1;
    end
  end

  always_comb begin
    base  = ctx_i;
    dec_o = '0;
    ctx_o = ctx_i;
    if (cmd_i == CMD_EOT) begin
      dec_o.emit  = ctx_i.text_open;
      dec_o.clear = 1'b1;
      ctx_o       = '0;
    end else begin
      if (!ctx_i.text_open) begin
        base.ri_run_odd     = 1'b0;
        base.after_zwj      = 1'b0;
        base.last_base_pict = 1'b0;
        dec_o.open          = 1'b1;
      end else if (bnd) begin
        dec_o.emit = 1'b1;
        dec_o.open = 1'b1;
      end
      ctx_o.text_open  = 1'b1;
      ctx_o.prev_class = cls;
      ctx_o.ri_run_odd = (cls == CLS_RI) ? !base.ri_run_odd : 1'b0;
      if (cls == CLS_EXTEND) begin
        ctx_o.after_zwj      = 1'b0;
        ctx_o.last_base_pict = base.last_base_pict;
      end else if (cls == CLS_ZWJ) begin
        ctx_o.after_zwj      = base.last_base_pict;
        ctx_o.last_base_pict = 1'b0;
      end else begin
        ctx_o.after_zwj      = 1'b0;
        ctx_o.last_base_pict = pict_i;
      end
    end
  end

endmodule

// File: design/grapheme_cluster_segmenter_core.sv
// Top level of the grapheme cluster segmenter: input register, rule logic,
// offset tracking and output register. Depends on gcs_pkg, gcs_in_if,
// gcs_out_if and gcs_rules.
//
//   port        dir  beat carries
//   in_chan_i   in   cmd, gb_class, is_pictographic, cp_bytes
//   out_chan_o  out  cluster_start, cluster_len
//
// One input beat is taken every cycle while the output is not stalled; a result
// passes through the input register and then the output register.
// A stalled output holds its beat and blocks the input register behind it;
// a new input beat is still taken in the cycle the held result drains.
// Reset clears the context and both offsets; no clearing pass is needed.
module grapheme_cluster_segmenter_core import gcs_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gcs_in_if.sink    in_chan_i,
  gcs_out_if.source out_chan_o
);

  logic                   s1_valid_q;
  logic                   cmd_q;
  logic [CLASS_W-1:0]     class_q;
  logic                   pict_q;
  logic [BYTES_W-1:0]     bytes_q;

  ctx_t                   ctx_q;
  ctx_t                   ctx_d;
  dec_t                   dec;
  logic [OFFSET_BITS-1:0] byte_offset_q;
  logic [OFFSET_BITS-1:0] byte_offset_d;
  logic [OFFSET_BITS-1:0] cluster_begin_q;
  logic [OFFSET_BITS-1:0] cluster_begin_d;

  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_start_q;
  logic [OUT_W-1:0]       out_len_q;

  logic                   out_free;
  logic                   s1_fire;
  logic                   in_fire;

  assign out_free        = !out_valid_q || out_chan_o.ready;
  assign s1_fire         = s1_valid_q && out_free;
  assign in_chan_i.ready = !s1_valid_q || out_free;
  assign in_fire         = in_chan_i.valid && in_chan_i.ready;

  gcs_rules u_rules (
    .ctx_i      (ctx_q),
    .cmd_i      (cmd_q),
    .gb_class_i (class_q),
    .pict_i     (pict_q),
    .ctx_o      (ctx_d),
    .dec_o      (dec)
  );

  always_comb begin
    byte_offset_d   = byte_offset_q + OFFSET_BITS'(bytes_q);
    cluster_begin_d = cluster_begin_q;
    if (dec.clear) begin
      byte_offset_d   = '0;
      cluster_begin_d = '0;
    end else if (dec.open) begin
      cluster_begin_d = byte_offset_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      ctx_q           <= '0;
      byte_offset_q   <= '0;
      cluster_begin_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        ctx_q           <= ctx_d;
        byte_offset_q   <= byte_offset_d;
        cluster_begin_q <= cluster_begin_d;
      end
      if (s1_fire && dec.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= in_chan_i.cmd;
      class_q <= in_chan_i.gb_class;
      pict_q  <= in_chan_i.is_pictographic;
      bytes_q <= in_chan_i.cp_bytes;
    end
    if (s1_fire && dec.emit) begin
      out_start_q <= OUT_W'(cluster_begin_q);
      out_len_q   <= OUT_W'(byte_offset_q - cluster_begin_q);
    end
  end

  assign out_chan_o.valid         = out_valid_q;
  assign out_chan_o.cluster_start = out_start_q;
  assign out_chan_o.cluster_len   = out_len_q;

  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && cmd_q == CMD_EOT |=> byte_offset_q == '0 && !ctx_q.text_open)
    else $error("end of text left state behind");

  a_emit_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && dec.emit |-> ctx_q.text_open)
    else $error("cluster emitted with none open");

  a_zwj_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_q.after_zwj |-> ctx_q.prev_class == CLS_ZWJ)
    else $error("pending join without preceding ZWJ");

  a_ri_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_q.ri_run_odd |-> ctx_q.prev_class == CLS_RI)
    else $error("odd RI run without preceding RI");

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && dec.emit |=> out_valid_q)
    else $error("emitted cluster not presented");

endmodule

// File: sim/tb_grapheme_cluster_segmenter_core.sv
`timescale 1ns / 1ps
// Testbench for grapheme_cluster_segmenter_core: directed and random code point streams
// with random idle and stall bursts, checked against an in-line cluster predictor.
// Depends on gcs_pkg, gcs_in_if, gcs_out_if and the core.
module tb_grapheme_cluster_segmenter_core;
  import gcs_pkg::*;

  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned RAND_ITEMS  = 750;
  localparam int unsigned TAIL_ITEMS  = 80;
  localparam int unsigned STALL_LIMIT = 500;
  localparam int unsigned DRAIN_WAIT  = 10;

  typedef struct packed {
    logic               cmd;
    logic [CLASS_W-1:0] gb_class;
    logic               pict;
    logic [BYTES_W-1:0] nbytes;
  } cp_beat_t;

  typedef struct packed {
    logic [OUT_W-1:0] cl_start;
    logic [OUT_W-1:0] cl_len;
  } cluster_t;

  logic clk_i;
  logic rst_ni;

  gcs_in_if  in_bus ();
  gcs_out_if out_bus ();

  grapheme_cluster_segmenter_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan_i (in_bus),
    .out_chan_o(out_bus)
  );

  cp_beat_t text_stream_q[$];
  cluster_t cluster_q[$];

  gb_class_e              prev_cls;
  bit                     open_cluster;
  bit                     ri_odd;
  bit                     zwj_join;
  bit                     base_pict;
  logic [OFFSET_BITS-1:0] begin_off;
  logic [OFFSET_BITS-1:0] cur_off;

  int  errors;
  int  items_seen;
  int  texts_seen;
  int  clusters_checked;
  int  gap_left;
  int  stall_left;
  int  quiet_cycles;
  bit  tail_phase;

  function automatic void clear_context();
    prev_cls     = CLS_OTHER;
    open_cluster = 1'b0;
    ri_odd       = 1'b0;
    zwj_join     = 1'b0;
    base_pict    = 1'b0;
    begin_off    = '0;
    cur_off      = '0;
  endfunction

  function automatic bit is_ctl(gb_class_e k);
    return k == CLS_CR || k == CLS_LF || k == CLS_CONTROL;
  endfunction

  function automatic bit breaks_before(gb_class_e c, logic pict);
    if (prev_cls == CLS_CR && c == CLS_LF) return 1'b0;
    if (is_ctl(prev_cls) || is_ctl(c)) return 1'b1;
    if (prev_cls == CLS_L && (c == CLS_L || c == CLS_V || c == CLS_LV || c == CLS_LVT))
      return 1'b0;
    if ((prev_cls == CLS_LV || prev_cls == CLS_V) && (c == CLS_V || c == CLS_T)) return 1'b0;
    if ((prev_cls == CLS_LVT || prev_cls == CLS_T) && c == CLS_T) return 1'b0;
    if (c == CLS_EXTEND || c == CLS_ZWJ) return 1'b0;
    if (c == CLS_SPACING) return 1'b0;
    if (prev_cls == CLS_PREPEND) return 1'b0;
    if (pict && zwj_join) return 1'b0;
    if (prev_cls == CLS_RI && c == CLS_RI && ri_odd) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the segmentation state by one accepted beat.
  function automatic void segment_step(cp_beat_t b);
    gb_class_e              c;
    logic [OFFSET_BITS-1:0] span;
    c    = (b.gb_class > CLS_LVT) ? CLS_OTHER : gb_class_e'(b.gb_class);
    span = cur_off - begin_off;
    if (b.cmd == CMD_EOT) begin
      if (open_cluster) cluster_q.push_back('{begin_off[OUT_W-1:0], span[OUT_W-1:0]});
      clear_context();
      texts_seen++;
      return;
    end
    if (!open_cluster) begin
      open_cluster = 1'b1;
      begin_off    = cur_off;
      ri_odd       = 1'b0;
      zwj_join     = 1'b0;
      base_pict    = 1'b0;
    end else if (breaks_before(c, b.pict)) begin
      cluster_q.push_back('{begin_off[OUT_W-1:0], span[OUT_W-1:0]});
      begin_off = cur_off;
    end
    ri_odd = (c == CLS_RI) ? !ri_odd : 1'b0;
    if (c == CLS_EXTEND) begin
      zwj_join = 1'b0;
    end else if (c == CLS_ZWJ) begin
      zwj_join  = base_pict;
      base_pict = 1'b0;
    end else begin
      base_pict = b.pict;
      zwj_join  = 1'b0;
    end
    prev_cls = c;
    cur_off  = cur_off + OFFSET_BITS'(b.nbytes);
  endfunction

  function automatic void push_cp(logic cmd, logic [CLASS_W-1:0] cls, logic pict,
                                  logic [BYTES_W-1:0] nb);
    text_stream_q.push_back('{cmd, cls, pict, nb});
  endfunction

  function automatic logic [BYTES_W-1:0] rand_bytes();
    if ($urandom_range(0, 9) == 0) return BYTES_W'($urandom_range(0, 7));
    return BYTES_W'($urandom_range(1, 4));
  endfunction

  function automatic void push_rand_cp();
    int                 r;
    logic [CLASS_W-1:0] cls;
    logic               pict;
    r    = $urandom_range(0, 99);
    pict = ($urandom_range(0, 7) == 0);
    if (r < 30) begin
      cls  = CLS_OTHER;
      pict = 1'($urandom_range(0, 1));
    end else if (r < 38) cls = CLS_EXTEND;
    else if (r < 46) cls = CLS_ZWJ;
    else if (r < 52) cls = CLS_SPACING;
    else if (r < 57) cls = CLS_PREPEND;
    else if (r < 67) cls = CLS_RI;
    else if (r < 80) cls = CLASS_W'($urandom_range(CLS_L, CLS_LVT));
    else if (r < 88) cls = CLASS_W'($urandom_range(CLS_CR, CLS_CONTROL));
    else if (r < 92) cls = CLASS_W'($urandom_range(14, 15));
    else begin
      cls  = CLASS_W'($urandom_range(0, 15));
      pict = 1'($urandom_range(0, 1));
    end
    push_cp(CMD_CP, cls, pict, rand_bytes());
  endfunction

  function automatic void push_eot();
    push_cp(CMD_EOT, CLASS_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), rand_bytes());
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive the input channel from the pending code point stream.
  always @(posedge clk_i or negedge rst_ni) begin
    cp_beat_t nxt;
    if (!rst_ni) begin
      in_bus.valid           <= 1'b0;
      in_bus.cmd             <= CMD_CP;
      in_bus.gb_class        <= CLS_OTHER;
      in_bus.is_pictographic <= 1'b0;
      in_bus.cp_bytes        <= '0;
      gap_left               <= 0;
      tail_phase             <= 1'b0;
    end else begin
      tail_phase <= (text_stream_q.size() < TAIL_ITEMS);
      if (in_bus.valid && in_bus.ready) begin
        segment_step('{in_bus.cmd, in_bus.gb_class, in_bus.is_pictographic, in_bus.cp_bytes});
        items_seen++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          in_bus.valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (text_stream_q.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
          in_bus.valid <= 1'b0;
          gap_left     <= $urandom_range(0, 3);
        end else begin
          nxt                    = text_stream_q.pop_front();
          in_bus.valid           <= 1'b1;
          in_bus.cmd             <= nxt.cmd;
          in_bus.gb_class        <= nxt.gb_class;
          in_bus.is_pictographic <= nxt.pict;
          in_bus.cp_bytes        <= nxt.nbytes;
        end
      end
    end
  end

  // Check each accepted cluster against the oldest expected one; stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    cluster_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (cluster_q.size() == 0) begin
          $display("%0t: unexpected cluster start %0d len %0d", $time,
                   out_bus.cluster_start, out_bus.cluster_len);
          errors++;
        end else begin
          want = cluster_q.pop_front();
          clusters_checked++;
          if (out_bus.cluster_start !== want.cl_start) begin
            $display("%0t: cluster_start expected %0d, actual %0d", $time,
                     want.cl_start, out_bus.cluster_start);
            errors++;
          end
          if (out_bus.cluster_len !== want.cl_len) begin
            $display("%0t: cluster_len expected %0d, actual %0d", $time,
                     want.cl_len, out_bus.cluster_len);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left    <= $urandom_range(0, 3);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Abort when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("tb_grapheme_cluster_segmenter_core NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int n_cp;
    int k;
    int r;
    rst_ni                 = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.cmd             = CMD_CP;
    in_bus.gb_class        = CLS_OTHER;
    in_bus.is_pictographic = 1'b0;
    in_bus.cp_bytes        = '0;
    out_bus.ready          = 1'b0;
    errors                 = 0;
    items_seen             = 0;
    texts_seen             = 0;
    clusters_checked       = 0;
    quiet_cycles           = 0;
    clear_context();

    // end of text with nothing open, then a zero-length cluster
    push_cp(CMD_EOT, CLS_OTHER,   1'b0, 3'd1);
    push_cp(CMD_CP,  CLS_OTHER,   1'b0, 3'd0);
    push_cp(CMD_EOT, CLS_OTHER,   1'b0, 3'd1);
    // control handling, Hangul runs, prepend, joiners, emoji ZWJ, spacing mark, RI pairing, out-of-range classes
    push_cp(CMD_CP,  CLS_CR,      1'b0, 3'd1);
    push_cp(CMD_CP,  CLS_LF,      1'b0, 3'd1);
    push_cp(CMD_CP,  CLS_CONTROL, 1'b0, 3'd2);
    push_cp(CMD_CP,  CLS_L,       1'b0, 3'd3);
    push_cp(CMD_CP,  CLS_V,       1'b0, 3'd3);
    push_cp(CMD_CP,  CLS_T,       1'b0, 3'd3);
    push_cp(CMD_CP,  CLS_LV,      1'b0, 3'd3);
    push_cp(CMD_CP,  CLS_LVT,     1'b0, 3'd3);
    push_cp(CMD_CP,  CLS_T,       1'b0, 3'd3);
    push_cp(CMD_CP,  CLS_PREPEND, 1'b0, 3'd1);
    push_cp(CMD_CP,  CLS_OTHER,   1'b1, 3'd4);
    push_cp(CMD_CP,  CLS_EXTEND,  1'b0, 3'd2);
    push_cp(CMD_CP,  CLS_ZWJ,     1'b0, 3'd3);
    push_cp(CMD_CP,  CLS_OTHER,   1'b1, 3'd4);
    push_cp(CMD_CP,  CLS_SPACING, 1'b0, 3'd3);
    push_cp(CMD_CP,  CLS_RI,      1'b0, 3'd4);
    push_cp(CMD_CP,  CLS_RI,      1'b0, 3'd4);
    push_cp(CMD_CP,  CLS_RI,      1'b0, 3'd4);
    push_cp(CMD_CP,  4'd15,       1'b1, 3'd7);
    push_cp(CMD_CP,  4'd14,       1'b0, 3'd5);
    push_cp(CMD_EOT, 4'd15,       1'b1, 3'd7);

    n_cp = text_stream_q.size();
    while (text_stream_q.size() < n_cp + RAND_ITEMS) begin
      for (k = $urandom_range(1, 10); k > 0; k--) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          push_cp(CMD_CP, CLS_OTHER, 1'b1, 3'd4);
          repeat ($urandom_range(0, 2)) push_cp(CMD_CP, CLS_EXTEND, 1'b0, rand_bytes());
          push_cp(CMD_CP, CLS_ZWJ, 1'b0, 3'd3);
          push_cp(CMD_CP, CLS_OTHER, $urandom_range(0, 3) != 0, 3'd4);
        end else if (r == 1) begin
          push_cp(CMD_CP, CLS_CR, 1'b0, 3'd1);
          push_cp(CMD_CP, CLS_LF, 1'b0, 3'd1);
        end else if (r == 2) begin
          repeat ($urandom_range(2, 5)) push_cp(CMD_CP, CLS_RI, 1'b0, 3'd4);
        end else begin
          push_rand_cp();
        end
      end
      if ($urandom_range(0, 19) != 0) push_eot();
      if ($urandom_range(0, 29) == 0) push_eot();
    end
    push_eot();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (text_stream_q.size() != 0 || in_bus.valid) @(posedge clk_i);
    while (cluster_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d beats in %0d texts, %0d clusters compared", items_seen,
             texts_seen, clusters_checked);
    $display("with CR-LF, control, Hangul, joiner, emoji ZWJ and RI pairing rules");
    if (errors == 0) begin
      $display("tb_grapheme_cluster_segmenter_core OK");
    end else begin
      $display("tb_grapheme_cluster_segmenter_core NOT OK");
    end
    $finish;
  end

endmodule
